[rtl/core/keyframe_linear_decimator_defines.svh]
// Assertion macros for the keyframe linear decimator.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef KEYFRAME_LINEAR_DECIMATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_DECIMATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KLD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe decimator check failed");

// next-cycle implication, disabled while reset is asserted
`define KLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe decimator check failed");

`endif

[rtl/core/kld_pkg.sv]
// Shared widths, constants and the queue entry type of the keyframe decimator.
// No dependencies.
package kld_pkg;

    localparam int TIME_W = 24;
    localparam int WORD_W = 32;
    localparam int TOL_W  = 31;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    localparam int KLD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [WORD_W-1:0] key_value;
        logic [WORD_W-1:0] in_slope;
        logic [WORD_W-1:0] out_slope;
        logic              final_key;
        logic              first_key;  // first key of a curve
    } t_entry;

endpackage

[rtl/core/kld_intf.sv]
// Channel interfaces of the keyframe decimator: key input, kept output, config.
// Depends on kld_pkg.
interface kld_key_if;
    import kld_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] key_time;
    logic [WORD_W-1:0] key_value;
    logic [WORD_W-1:0] in_slope;
    logic [WORD_W-1:0] out_slope;
    logic              final_key;
    modport source(output valid, key_time, key_value, in_slope, out_slope, final_key,
                   input ready);
    modport sink(input valid, key_time, key_value, in_slope, out_slope, final_key,
                 output ready);
endinterface

interface kld_kept_if;
    import kld_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] kept_time;
    logic [WORD_W-1:0] kept_value;
    logic [WORD_W-1:0] kept_in_slope;
    logic [WORD_W-1:0] kept_out_slope;
    logic              is_last;
    modport source(output valid, kept_time, kept_value, kept_in_slope, kept_out_slope,
                   is_last, input ready);
    modport sink(input valid, kept_time, kept_value, kept_in_slope, kept_out_slope,
                 is_last, output ready);
endinterface

interface kld_cfg_if;
    import kld_pkg::*;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] error_tolerance;
    modport source(output valid, error_tolerance, input ready);
    modport sink(input valid, error_tolerance, output ready);
endinterface

[rtl/core/kld_front.sv]
// Front end: accepts key beats, tags the first key of each curve, pushes to the queue.
// Depends on kld_pkg and kld_intf.
module kld_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kld_key_if.sink         i_key,
    input  logic            i_full,
    output logic            o_push,
    output kld_pkg::t_entry o_entry
);
    import kld_pkg::*;

    logic r_started;

    assign i_key.ready = !i_full;
    assign o_push      = i_key.valid && !i_full;

    always_comb begin
        o_entry.key_time  = i_key.key_time;
        o_entry.key_value = i_key.key_value;
        o_entry.in_slope  = i_key.in_slope;
        o_entry.out_slope = i_key.out_slope;
        o_entry.final_key = i_key.final_key;
        o_entry.first_key = !r_started;
    end

    // a curve is open from its first key until its final key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (o_push) begin
            r_started <= !i_key.final_key;
        end
    end

endmodule

[rtl/core/kld_queue.sv]
// Small FIFO of classified keys between the front end and the back end.
// Depends on kld_pkg.
module kld_queue #(
    parameter int DEPTH = kld_pkg::KLD_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kld_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kld_pkg::t_entry o_head
);
    import kld_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/kld_back.sv]
// Back end: judges the held key with one shared multiplier, owns the tolerance
// register and the output register. Depends on kld_pkg, kld_intf and the defines.
`include "keyframe_linear_decimator_defines.svh"

module kld_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  kld_pkg::t_entry i_head,
    output logic            o_pop,
    kld_cfg_if.sink         i_cfg,
    kld_kept_if.source      o_kept
);
    import kld_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_MUL3 = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [TIME_W-1:0]  r_ref_time;
    logic [WORD_W-1:0]  r_ref_value;
    logic               r_held_valid;
    t_entry             r_held;
    t_entry             r_cur;

    logic signed [24:0] r_d;
    logic signed [24:0] r_dc;
    logic signed [32:0] r_dvc;
    logic signed [32:0] r_dvn;
    logic [TIME_W-1:0]  r_abs_d;
    logic signed [57:0] r_prod;
    logic signed [58:0] r_err;

    logic               r_out_valid;
    t_entry             r_out;
    logic               r_out_last;

    logic signed [24:0] w_d;
    logic signed [24:0] w_dc;
    logic signed [32:0] w_dvc;
    logic signed [32:0] w_dvn;
    logic signed [32:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [57:0] w_prod;
    logic signed [58:0] w_lim;
    logic               w_need;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_out_last;
    logic               w_emit_held;
    logic               w_emit_cur;
    logic               w_take_direct;
    logic               w_hold_cur;

    assign i_cfg.ready = 1'b1;

    // differences against the reference, taken as the head is popped
    assign w_d   = $signed({1'b0, i_head.key_time}) - $signed({1'b0, r_ref_time});
    assign w_dc  = $signed({1'b0, r_held.key_time}) - $signed({1'b0, r_ref_time});
    assign w_dvc = $signed({r_held.key_value[WORD_W-1], r_held.key_value})
                 - $signed({r_ref_value[WORD_W-1], r_ref_value});
    assign w_dvn = $signed({i_head.key_value[WORD_W-1], i_head.key_value})
                 - $signed({r_ref_value[WORD_W-1], r_ref_value});

    // shared multiplier: dvc*d, then dvn*dc, then tol*|d|
    always_comb begin
        case (r_state)
            ST_MUL1: begin
                w_mul_a = r_dvc;
                w_mul_b = r_d;
            end
            ST_MUL2: begin
                w_mul_a = r_dvn;
                w_mul_b = r_dc;
            end
            default: begin
                w_mul_a = $signed({2'b00, r_tol});
                w_mul_b = $signed({1'b0, r_abs_d});
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // keep when |E| > tol*|D|, or when the span is zero
    assign w_lim  = {r_prod[57], r_prod};
    assign w_need = (r_d == '0) || (r_err > w_lim) || (r_err < -w_lim);

    assign w_out_free = !r_out_valid || o_kept.ready;

    always_comb begin
        n_state       = r_state;
        o_pop         = 1'b0;
        w_emit_held   = 1'b0;
        w_emit_cur    = 1'b0;
        w_take_direct = 1'b0;
        w_hold_cur    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.first_key) begin
                        n_state = ST_FIN;
                    end else if (r_held_valid) begin
                        n_state = ST_MUL1;
                    end else if (i_head.final_key) begin
                        n_state = ST_FIN;
                    end else begin
                        w_take_direct = 1'b1;
                    end
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_DEC;
            ST_DEC: begin
                if (!w_need || w_out_free) begin
                    w_emit_held = w_need;
                    if (r_cur.final_key) begin
                        n_state = ST_FIN;
                    end else begin
                        w_hold_cur = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_emit_cur = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_out_load = w_emit_held || w_emit_cur;
    assign w_out_last = w_emit_cur && r_cur.final_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tol        <= TOL_RESET;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_tol <= i_cfg.error_tolerance;
            end
            if (w_take_direct || w_hold_cur) begin
                r_held_valid <= 1'b1;
            end else if (w_emit_cur) begin
                r_held_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_kept.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
            r_d   <= w_d;
            r_dc  <= w_dc;
            r_dvc <= w_dvc;
            r_dvn <= w_dvn;
        end
        if (w_take_direct) begin
            r_held <= i_head;
        end else if (w_hold_cur) begin
            r_held <= r_cur;
        end
        if (w_emit_held) begin
            r_ref_time  <= r_held.key_time;
            r_ref_value <= r_held.key_value;
        end else if (w_emit_cur && r_cur.first_key && !r_cur.final_key) begin
            r_ref_time  <= r_cur.key_time;
            r_ref_value <= r_cur.key_value;
        end
        if (r_state == ST_MUL1) begin
            r_abs_d <= r_d[24] ? TIME_W'(-r_d) : r_d[TIME_W-1:0];
        end
        if (r_state == ST_MUL2) begin
            r_err <= {r_prod[57], r_prod};
        end else if (r_state == ST_MUL3) begin
            r_err <= r_err - {r_prod[57], r_prod};
        end
        if (r_state == ST_MUL1 || r_state == ST_MUL2 || r_state == ST_MUL3) begin
            r_prod <= w_prod;
        end
        if (w_out_load) begin
            r_out      <= w_emit_held ? r_held : r_cur;
            r_out_last <= w_out_last;
        end
    end

    assign o_kept.valid          = r_out_valid;
    assign o_kept.kept_time      = r_out.key_time;
    assign o_kept.kept_value     = r_out.key_value;
    assign o_kept.kept_in_slope  = r_out.in_slope;
    assign o_kept.kept_out_slope = r_out.out_slope;
    assign o_kept.is_last        = r_out_last;

    `KLD_ASSERT_HOLDS(a_pop_only_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE)
    `KLD_ASSERT_HOLDS(a_load_states, i_clk, i_rst_n, w_out_load, (r_state == ST_DEC) || (r_state == ST_FIN))
    `KLD_ASSERT_NEXT(a_last_drops_held, i_clk, i_rst_n, w_out_load && w_out_last, !r_held_valid)
    `KLD_ASSERT_NEXT(a_mul_sequence, i_clk, i_rst_n, r_state == ST_MUL1, r_state == ST_MUL2)

endmodule

[rtl/core/keyframe_linear_decimator.sv]
// Channel    Dir  Modport        Payload
// i_key      in   kld_key_if     key_time, key_value, in_slope, out_slope, final_key
// o_kept     out  kld_kept_if    kept_time, kept_value, kept_in_slope, kept_out_slope, is_last
// i_cfg      in   kld_cfg_if     error_tolerance (always ready)
//
// A key judged against a held key passes the back-end states MUL1, MUL2, MUL3 and DEC (and FIN
// when it is final, whether or not the held key goes out): three passes through one shared 33x25
// multiplier, then the keep compare. Other keys go to FIN or are held directly. Synchronous
// active-low reset, no clearing pass. A QUEUE_DEPTH-entry queue lets the front accept
// beats while the back works; an output register lets the back run while a result waits.
// Depends on kld_pkg, kld_intf, kld_front, kld_queue and kld_back.
module keyframe_linear_decimator #(
    parameter int QUEUE_DEPTH = kld_pkg::KLD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kld_key_if.sink    i_key,
    kld_kept_if.source o_kept,
    kld_cfg_if.sink    i_cfg
);
    import kld_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_head_valid;
    t_entry w_entry;
    t_entry w_head;

    kld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_key),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    kld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    kld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_cfg        (i_cfg),
        .o_kept       (o_kept)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for keyframe_linear_decimator: keys in, kept keys out, tolerance port.
// Keeps its own copy of the keep/drop logic and checks every kept beat against it.
// Depends on kld_pkg, the kld_*_if interfaces and the RTL under rtl/core.
module testbench;
    import kld_pkg::*;

    localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on any channel
    localparam int SETTLE_CYCLES = 40;    // queue entries plus back-end passes, with margin
    localparam int PRINT_CAP     = 60;
    localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] tm;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] slope_in;
        logic [WORD_W-1:0] slope_out;
        logic              last;
    } t_keyframe;

    logic clk;
    logic rst_n;

    kld_key_if  key_ch ();
    kld_kept_if kept_ch ();
    kld_cfg_if  cfg_ch ();

    keyframe_linear_decimator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_key   (key_ch),
        .o_kept  (kept_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow of the decimator state
    logic [TOL_W-1:0]  tolerance;
    logic              curve_open;
    logic [TIME_W-1:0] anchor_time;
    logic [WORD_W-1:0] anchor_value;
    logic              pend_valid;
    t_keyframe         pend_key;

    t_keyframe kept_expected[$];
    int        mismatch_count;
    int        keys_sent;
    int        send_idle_pct;
    int        stall_pct;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic t_keyframe key_at(logic [TIME_W-1:0] t, logic [WORD_W-1:0] v,
                                         logic [WORD_W-1:0] si, logic [WORD_W-1:0] so,
                                         logic fin);
        t_keyframe k;
        k.tm        = t;
        k.val       = v;
        k.slope_in  = si;
        k.slope_out = so;
        k.last      = fin;
        return k;
    endfunction

    // held key survives if the span is zero or it strays from the anchor-to-successor line by more than tolerance
    function automatic bit pend_is_needed(logic [TIME_W-1:0] nt, logic [WORD_W-1:0] nv);
        longint span, off, rise_pend, rise_next, err, lim;
        span      = longint'(nt) - longint'(anchor_time);
        off       = longint'(pend_key.tm) - longint'(anchor_time);
        rise_pend = longint'($signed(pend_key.val)) - longint'($signed(anchor_value));
        rise_next = longint'($signed(nv)) - longint'($signed(anchor_value));
        if (span == 0)
            return 1'b1;
        err = rise_pend * span - rise_next * off;
        if (err < 0)
            err = -err;
        if (span < 0)
            span = -span;
        lim = longint'(tolerance) * span;
        return err > lim;
    endfunction

    task automatic track_key(input t_keyframe k);
        t_keyframe out;
        if (!curve_open) begin
            kept_expected.push_back(k);
            pend_valid = 1'b0;
            if (!k.last) begin
                curve_open   = 1'b1;
                anchor_time  = k.tm;
                anchor_value = k.val;
            end
        end else begin
            if (pend_valid && pend_is_needed(k.tm, k.val)) begin
                out      = pend_key;
                out.last = 1'b0;
                kept_expected.push_back(out);
                anchor_time  = pend_key.tm;
                anchor_value = pend_key.val;
            end
            if (k.last) begin
                kept_expected.push_back(k);
                curve_open = 1'b0;
                pend_valid = 1'b0;
            end else begin
                pend_valid = 1'b1;
                pend_key   = k;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // valid stays high across back-to-back beats; it only drops when a gap is taken
    task automatic send_key(input t_keyframe k);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            key_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        key_ch.valid     <= 1'b1;
        key_ch.key_time  <= k.tm;
        key_ch.key_value <= k.val;
        key_ch.in_slope  <= k.slope_in;
        key_ch.out_slope <= k.slope_out;
        key_ch.final_key <= k.last;
        do @(posedge clk); while (!key_ch.ready);
        track_key(k);
        keys_sent++;
    endtask

    task automatic drain_and_settle();
        key_ch.valid <= 1'b0;
        while (kept_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] tol_val);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.error_tolerance <= tol_val;
        do @(posedge clk); while (!cfg_ch.ready);
        tolerance = tol_val;
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk) begin : check_kept
        t_keyframe want;
        if (rst_n && kept_ch.valid && kept_ch.ready) begin
            if (kept_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected kept beat t=%h v=%h",
                                          kept_ch.kept_time, kept_ch.kept_value));
            end else begin
                want = kept_expected.pop_front();
                if (kept_ch.kept_time !== want.tm)
                    report_mismatch($sformatf("kept_time %h, want %h",
                                              kept_ch.kept_time, want.tm));
                if (kept_ch.kept_value !== want.val)
                    report_mismatch($sformatf("kept_value %h, want %h",
                                              kept_ch.kept_value, want.val));
                if (kept_ch.kept_in_slope !== want.slope_in)
                    report_mismatch($sformatf("kept_in_slope %h, want %h",
                                              kept_ch.kept_in_slope, want.slope_in));
                if (kept_ch.kept_out_slope !== want.slope_out)
                    report_mismatch($sformatf("kept_out_slope %h, want %h",
                                              kept_ch.kept_out_slope, want.slope_out));
                if (kept_ch.is_last !== want.last)
                    report_mismatch($sformatf("is_last %b, want %b",
                                              kept_ch.is_last, want.last));
            end
        end
    end

    always @(posedge clk)
        kept_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((key_ch.valid && key_ch.ready) || (kept_ch.valid && kept_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // lone final key, then first key followed directly by final key; field extremes
    task automatic test_endpoints();
        send_key(key_at(24'h000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_key(key_at(24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_key(key_at(24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    endtask

    // runs on the reset tolerance of 66: error exactly at the limit drops, one above keeps
    task automatic test_drop_threshold();
        send_key(key_at(24'd0, 32'd0, 32'h1234_5678, 32'hEDCB_A987, 1'b0));
        send_key(key_at(24'd1, 32'd66, 32'd11, 32'd12, 1'b0));
        send_key(key_at(24'd2, 32'd0, 32'd21, 32'd22, 1'b0));
        send_key(key_at(24'd4, 32'd200, 32'd31, 32'd32, 1'b0));
        send_key(key_at(24'd6, 32'd400, 32'd41, 32'd42, 1'b1));
        // held key kept together with the final key
        send_key(key_at(24'd10, 32'd100, -32'd1, -32'd2, 1'b0));
        send_key(key_at(24'd11, 32'd5000, -32'd3, -32'd4, 1'b0));
        send_key(key_at(24'd12, 32'd100, -32'd5, -32'd6, 1'b1));
        send_key(key_at(24'd0, 32'd0, 32'd7, 32'd8, 1'b0));
        send_key(key_at(24'd1, 32'd67, 32'd9, 32'd10, 1'b0));
        send_key(key_at(24'd2, 32'd0, 32'd13, 32'd14, 1'b1));
    endtask

    // zero time span keeps the held key; times running backward use the magnitude of span
    task automatic test_special_spans();
        send_key(key_at(24'd500, 32'd1000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0));
        send_key(key_at(24'd500, 32'd9999, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0));
        send_key(key_at(24'd500, 32'd1000, 32'd1, 32'd2, 1'b0));
        send_key(key_at(24'd100, 32'd3, 32'd3, 32'd4, 1'b1));
        send_key(key_at(24'd1000, 32'd0, 32'd5, 32'd6, 1'b0));
        send_key(key_at(24'd900, 32'd0, 32'd7, 32'd8, 1'b0));
        send_key(key_at(24'd800, 32'd0, 32'd9, 32'd10, 1'b1));
    endtask

    task automatic test_tolerance_extremes();
        drain_and_settle();
        write_tolerance('0);
        send_key(key_at(24'd0, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(key_at(24'd1, 32'd1, 32'd0, 32'd0, 1'b0));
        send_key(key_at(24'd2, 32'd2, 32'd0, 32'd0, 1'b1));
        drain_and_settle();
        write_tolerance(TOL_MAX);
        send_key(key_at(24'd0, 32'h8000_0000, 32'd1, 32'd1, 1'b0));
        send_key(key_at(24'd5, 32'h7FFF_FFFF, 32'd2, 32'd2, 1'b0));
        send_key(key_at(24'hFFFFFF, 32'h8000_0000, 32'd3, 32'd3, 1'b1));
    endtask

    // mostly noisy points around a line, with repeated times, backward steps and wild values
    task automatic send_random_curve();
        int          n_keys;
        int          flavor;
        int unsigned amp;
        logic [TIME_W-1:0] t;
        longint      base, rate, elapsed, step, noise, v;
        t_keyframe   k;
        n_keys  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
        t       = TIME_W'($urandom());
        base    = longint'($signed($urandom()));
        rate    = longint'($urandom_range(0, 4000)) - 2000;
        amp     = ((tolerance > 31'd1048576) ? 1048576 : int'(tolerance)) * 3 + 4;
        elapsed = 0;
        for (int i = 0; i < n_keys; i++) begin
            flavor = $urandom_range(0, 19);
            if (i > 0) begin
                if (flavor == 0)
                    step = -longint'($urandom_range(1, 3000));
                else if (flavor <= 2)
                    step = 0;
                else
                    step = longint'($urandom_range(1, 4096));
                t       = t + TIME_W'(step);
                elapsed = elapsed + step;
            end
            noise = longint'($urandom_range(0, 2 * amp)) - longint'(amp);
            v     = (flavor == 3) ? longint'($urandom()) : base + rate * elapsed + noise;
            k = key_at(t, WORD_W'(v), $urandom(), $urandom(),
                       (i == n_keys - 1) && ($urandom_range(0, 7) != 0));
            send_key(k);
        end
    endtask

    task automatic test_random_traffic();
        int target;
        logic [TOL_W-1:0] tol_pick;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                if (sub == 0)
                    tol_pick = TOL_W'($urandom_range(0, 400));
                else if (ph == 0)
                    tol_pick = '0;
                else if (ph == 1)
                    tol_pick = TOL_MAX;
                else if (ph == 2)
                    tol_pick = TOL_W'($urandom());
                else
                    tol_pick = TOL_RESET;
                drain_and_settle();
                write_tolerance(tol_pick);
                target = keys_sent + 62;
                while (keys_sent < target)
                    send_random_curve();
            end
        end
    endtask

    initial begin
        rst_n                  <= 1'b0;
        key_ch.valid           <= 1'b0;
        key_ch.key_time        <= '0;
        key_ch.key_value       <= '0;
        key_ch.in_slope        <= '0;
        key_ch.out_slope       <= '0;
        key_ch.final_key       <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.error_tolerance <= '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        keys_sent      = 0;
        tolerance      = TOL_RESET;
        curve_open     = 1'b0;
        anchor_time    = '0;
        anchor_value   = '0;
        pend_valid     = 1'b0;
        pend_key       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_endpoints();
        test_drop_threshold();
        test_special_spans();
        test_tolerance_extremes();
        test_random_traffic();

        drain_and_settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[keyframe_linear_decimator.f]
+incdir+rtl/core
rtl/core/kld_pkg.sv
rtl/core/kld_intf.sv
rtl/core/kld_front.sv
rtl/core/kld_queue.sv
rtl/core/kld_back.sv
rtl/core/keyframe_linear_decimator.sv
dv/testbench.sv
